>>> hw/rtl/swm_pkg.sv
// Shared constants, types and command/status bundles of the sliding window minimum block.
package swm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int POS_BITS    = 16;
  localparam int WIDTH_BITS  = 7;
  localparam int PTR_BITS    = $clog2(WINDOW_MAX);
  localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [POS_BITS-1:0]           pos_t;
  typedef logic [WIDTH_BITS-1:0]         width_t;
  typedef logic [PTR_BITS-1:0]           ptr_t;
  typedef logic [CNT_BITS-1:0]           cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRONT_RD,
    ST_FRONT_CHK,
    ST_BACK_RD,
    ST_BACK_CHK,
    ST_APPEND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic rd_front;
    logic rd_back;
    logic drop_head;
    logic keep_front;
    logic drop_tail;
    logic append;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic front_old;
    logic back_ge;
    logic has_result;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/swm_ctrl.sv
// Sequencer of the sliding window minimum block: steps each request through the deque.
module swm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  swm_pkg::status_t status,
  output swm_pkg::cmd_t    cmd
);
  import swm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_FRONT_RD;
      end
      ST_FRONT_RD: begin
        state_nxt = status.cnt_zero ? ST_APPEND : ST_FRONT_CHK;
      end
      ST_FRONT_CHK: begin
        state_nxt = status.front_old ? ST_FRONT_RD : ST_BACK_RD;
      end
      ST_BACK_RD: begin
        state_nxt = status.cnt_zero ? ST_APPEND : ST_BACK_CHK;
      end
      ST_BACK_CHK: begin
        state_nxt = status.back_ge ? ST_BACK_RD : ST_APPEND;
      end
      ST_APPEND: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!status.has_result || status.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_FRONT_RD: begin
        cmd.rd_front = !status.cnt_zero;
      end
      ST_FRONT_CHK: begin
        cmd.drop_head  = status.front_old;
        cmd.keep_front = !status.front_old;
      end
      ST_BACK_RD: begin
        cmd.rd_back = !status.cnt_zero;
      end
      ST_BACK_CHK: begin
        cmd.drop_tail = status.back_ge;
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = status.has_result && status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> hw/rtl/swm_datapath.sv
// Datapath of the sliding window minimum block: deque memory, pointers, counters, result register.
module swm_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  swm_pkg::width_t  cfg_wr_data,
  input  swm_pkg::sample_t in_sample,
  input  logic             in_start_sequence,
  input  swm_pkg::cmd_t    cmd,
  output swm_pkg::status_t status,
  output logic             out_valid,
  input  logic             out_ready,
  output swm_pkg::sample_t out_window_min,
  output swm_pkg::pos_t    out_window_start
);
  import swm_pkg::*;

  // deque storage, circular from head_r
  sample_t mem_val [WINDOW_MAX];
  pos_t    mem_pos [WINDOW_MAX];

  width_t  width_r;
  width_t  eff_w;
  sample_t sample_r;
  ptr_t    head_r;
  cnt_t    cnt_r;
  pos_t    pos_r;
  cnt_t    fill_r;
  cnt_t    fill_nxt;
  sample_t rd_val_r;
  pos_t    rd_pos_r;
  sample_t front_val_r;
  sample_t pend_min_r;
  pos_t    pend_start_r;
  logic    pend_vld_r;
  logic    out_valid_r;
  sample_t out_min_r;
  pos_t    out_start_r;
  ptr_t    rd_addr;
  ptr_t    wr_addr;
  pos_t    age;

  assign eff_w = (width_r == '0) ? width_t'(1) :
                 (width_r > width_t'(WINDOW_MAX)) ? width_t'(WINDOW_MAX) : width_r;

  assign rd_addr  = cmd.rd_front ? head_r : ptr_t'(head_r + cnt_r[PTR_BITS-1:0] - ptr_t'(1));
  assign wr_addr  = ptr_t'(head_r + cnt_r[PTR_BITS-1:0]);
  assign age      = pos_t'(pos_r - rd_pos_r);
  assign fill_nxt = (fill_r < cnt_t'(WINDOW_MAX)) ? cnt_t'(fill_r + cnt_t'(1)) : fill_r;

  assign status.cnt_zero   = (cnt_r == '0);
  assign status.front_old  = (age >= pos_t'(eff_w));
  assign status.back_ge    = (rd_val_r >= sample_r);
  assign status.has_result = pend_vld_r;
  assign status.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= width_t'(1);
    end else if (cfg_wr_en) begin
      width_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem_val[wr_addr] <= sample_r;
      mem_pos[wr_addr] <= pos_r;
    end
    if (cmd.rd_front || cmd.rd_back) begin
      rd_val_r <= mem_val[rd_addr];
      rd_pos_r <= mem_pos[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) sample_r <= in_sample;
    if (cmd.keep_front) front_val_r <= rd_val_r;
    if (cmd.append) begin
      pend_min_r   <= (cnt_r == '0) ? sample_r : front_val_r;
      pend_start_r <= pos_t'(pos_r + pos_t'(1) - pos_t'(eff_w));
    end
    if (cmd.load_out) begin
      out_min_r   <= pend_min_r;
      out_start_r <= pend_start_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      cnt_r       <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.latch && in_start_sequence) begin
        cnt_r  <= '0;
        pos_r  <= '0;
        fill_r <= '0;
      end
      if (cmd.latch) pend_vld_r <= 1'b0;
      if (cmd.drop_head) begin
        head_r <= ptr_t'(head_r + ptr_t'(1));
        cnt_r  <= cnt_t'(cnt_r - cnt_t'(1));
      end
      if (cmd.drop_tail) cnt_r <= cnt_t'(cnt_r - cnt_t'(1));
      if (cmd.append) begin
        cnt_r      <= cnt_t'(cnt_r + cnt_t'(1));
        pos_r      <= pos_t'(pos_r + pos_t'(1));
        fill_r     <= fill_nxt;
        pend_vld_r <= (fill_nxt >= cnt_t'(eff_w));
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        pend_vld_r  <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_min   = out_min_r;
  assign out_window_start = out_start_r;

endmodule

>>> hw/rtl/sliding_window_minimum.sv
// Top level of the sliding window minimum filter: sequencer, datapath and checks.
//
// Streaming minimum over the last window_width signed samples (1..64).
// Input channel: in_sample and in_start_sequence, moved by in_valid/in_ready.
// A request with in_start_sequence high begins a new sequence at index 0.
// Output channel: out_window_min and out_window_start by out_valid/out_ready;
// a result appears once window_width samples of the sequence have arrived.
// Configuration: cfg_wr_en writes cfg_wr_data into window_width at once;
// write it only while the block is idle. Zero acts as 1, above 64 as 64.
// Timing: one request at a time. Between acceptance and its result a
// request reads deque entries, front entries checked for age plus back
// entries compared, the back walk stopping at a smaller entry; the single
// read port of the deque memory sets the pace of this walk.
// The next request can be taken in the cycle after the previous one has been handed
// to the output register (or has ended without a result), even while that result waits for out_ready.
// A stalled receiver holds the result; a further result waits in its
// sequencer state until the output register frees.
// Reset (rst_n low, synchronous): empty deque, index 0, width 1, no output.
module sliding_window_minimum (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  swm_pkg::width_t  cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  swm_pkg::sample_t in_sample,
  input  logic             in_start_sequence,
  output logic             out_valid,
  input  logic             out_ready,
  output swm_pkg::sample_t out_window_min,
  output swm_pkg::pos_t    out_window_start
);
  import swm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: walks front checks, back checks, append, hand-off
  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // deque memory, counters and output register
  swm_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_sample         (in_sample),
    .in_start_sequence (in_start_sequence),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_window_min    (out_window_min),
    .out_window_start  (out_window_start)
  );

  // busy after a request is taken: no second request in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous still in progress");

  // never overwrite a result that the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // deque updates are exclusive
  a_deque_ops_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.drop_head, cmd.drop_tail, cmd.append, cmd.latch}))
    else $error("conflicting deque operations");

  // the deque never reads while idle
  a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.rd_front || cmd.rd_back))
    else $error("deque read while idle");

endmodule
